### rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock out of reset
`define RPMT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition implies consequence in the same cycle
`define RPMT_ASSERT_IMPL(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) else $error(msg);

`endif

### rtl/rpmt_pkg.sv
// Types and constants of the port mapping table.
// No dependencies.
package rpmt_pkg;

    localparam int unsigned DEF_TABLE_DEPTH = 16;
    localparam logic [31:0] LOOPBACK_ADDR   = 32'h0100_007F;
    localparam logic [31:0] LOW_START       = 32'h7FFF_FFFF;

    localparam logic [2:0] OP_REGISTER   = 3'd0;
    localparam logic [2:0] OP_UNREGISTER = 3'd1;
    localparam logic [2:0] OP_PORT_LOOK  = 3'd2;
    localparam logic [2:0] OP_CALL_LOOK  = 3'd3;
    localparam logic [2:0] OP_LOCAL_REG  = 3'd4;

    localparam logic [1:0] ST_DISPATCH    = 2'd0;
    localparam logic [1:0] ST_UNAVAILABLE = 2'd1;
    localparam logic [1:0] ST_MISMATCH    = 2'd2;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_INSERT,
        CMD_REMOVE,
        CMD_PORT,
        CMD_CALL
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [31:0]        prog;
        logic signed [31:0] vers;
        logic [7:0]         prot;
        logic [15:0]        port;
        logic               has_h;
        logic [3:0]         hid;
    } t_cmd;

    typedef struct packed {
        logic               success;
        logic [15:0]        port;
        logic [1:0]         status;
        logic [3:0]         handler;
        logic signed [31:0] vers_hi;
        logic signed [31:0] vers_lo;
    } t_result;

endpackage

### rtl/rpmt_fifo.sv
// Two-entry queue of beats, used between the stages and at the output.
// No dependencies.
module rpmt_fifo #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             do_wr, do_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_wr) r_wp <= ~r_wp;
            if (do_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end
endmodule

### rtl/rpmt_front.sv
// Front stage: accepts requests, checks the requester and classifies them.
// Depends on rpmt_pkg and rpmt_fifo.
module rpmt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [2:0]          i_operation,
    input  logic [31:0]         i_program_number,
    input  logic signed [31:0]  i_version,
    input  logic [7:0]          i_protocol,
    input  logic [15:0]         i_port_number,
    input  logic [3:0]          i_handler_id,
    input  logic [31:0]         i_requester_addr,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [31:0]         i_cfg_data,
    output rpmt_pkg::t_cmd      o_cmd,
    output logic                o_cmd_empty,
    input  logic                i_cmd_take
);
    import rpmt_pkg::*;

    logic [31:0] r_trusted;
    t_cmd        cmd;
    logic        trusted;
    logic [$bits(t_cmd)-1:0] cmd_bits;

    assign o_cfg_ready = 1'b1;
    assign trusted     = (i_requester_addr == r_trusted);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trusted <= LOOPBACK_ADDR;
        end else if (i_cfg_valid) begin
            r_trusted <= i_cfg_data;
        end
    end

    always_comb begin
        cmd.prog  = i_program_number;
        cmd.vers  = i_version;
        cmd.prot  = i_protocol;
        cmd.port  = i_port_number;
        cmd.has_h = 1'b0;
        cmd.hid   = 4'd0;
        unique case (i_operation)
            OP_REGISTER:   cmd.kind = trusted ? CMD_INSERT : CMD_NOP;
            OP_UNREGISTER: cmd.kind = trusted ? CMD_REMOVE : CMD_NOP;
            OP_PORT_LOOK:  cmd.kind = CMD_PORT;
            OP_CALL_LOOK:  cmd.kind = CMD_CALL;
            OP_LOCAL_REG: begin
                cmd.kind  = CMD_INSERT;
                cmd.has_h = 1'b1;
                cmd.hid   = i_handler_id;
            end
            default:       cmd.kind = CMD_NOP;
        endcase
    end

    rpmt_fifo #(.WIDTH($bits(t_cmd))) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata (cmd),
        .o_full  (full),
        .i_rd    (i_cmd_take),
        .o_rdata (cmd_bits),
        .o_empty (o_cmd_empty)
    );

    assign o_cmd = t_cmd'(cmd_bits);
endmodule

### rtl/rpmt_back.sv
// Back stage: the mapping table and the slot-by-slot scan that serves commands.
// Depends on rpmt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rpmt_back #(
    parameter int unsigned TABLE_DEPTH = rpmt_pkg::DEF_TABLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rpmt_pkg::t_cmd     i_cmd,
    input  logic               i_cmd_empty,
    output logic               o_cmd_take,
    output rpmt_pkg::t_result  o_res,
    output logic               o_res_wr,
    input  logic               i_res_full
);
    import rpmt_pkg::*;

    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state             r_state;
    t_cmd               r_cmd;
    logic [CW-1:0]      r_count, r_idx, r_wr;
    logic               r_hit, r_disp;
    logic [15:0]        r_port;
    logic [3:0]         r_handler;
    logic [1:0]         r_status;
    logic signed [31:0] r_hi, r_lo;

    logic [31:0]        r_prog [TABLE_DEPTH];
    logic signed [31:0] r_vers [TABLE_DEPTH];
    logic [7:0]         r_prot [TABLE_DEPTH];
    logic [15:0]        r_sport [TABLE_DEPTH];
    logic               r_hash [TABLE_DEPTH];
    logic [3:0]         r_hnd [TABLE_DEPTH];

    logic [IW-1:0]      ri, wi;
    logic               pv_match, tr_match, at_end, ins_ok, finish;
    logic               do_move, do_shift;

    assign ri       = r_idx[IW-1:0];
    assign wi       = r_wr[IW-1:0];
    assign pv_match = (r_prog[ri] == r_cmd.prog) && (r_vers[ri] == r_cmd.vers);
    assign tr_match = pv_match && (r_prot[ri] == r_cmd.prot);
    assign at_end   = (r_idx == r_count) || (r_cmd.kind == CMD_NOP);
    assign ins_ok   = !r_hit && (r_count < DEPTH_C);
    assign finish   = (r_state == S_DONE) && !i_res_full;
    assign do_move  = (r_state == S_SCAN) && !at_end && (r_cmd.kind == CMD_REMOVE)
                      && !pv_match && (r_wr != r_idx);
    assign do_shift = finish && (r_cmd.kind == CMD_INSERT) && ins_ok;

    assign o_cmd_take = (r_state == S_IDLE) && !i_cmd_empty;
    assign o_res_wr   = finish;

    always_comb begin
        o_res = '0;
        case (r_cmd.kind)
            CMD_INSERT: o_res.success = ins_ok;
            CMD_REMOVE: o_res.success = r_hit;
            CMD_PORT: begin
                o_res.success = 1'b1;
                o_res.port    = r_port;
            end
            CMD_CALL: begin
                o_res.success = 1'b1;
                if (r_disp) begin
                    o_res.status  = ST_DISPATCH;
                    o_res.handler = r_handler;
                end else begin
                    o_res.status  = r_status;
                    o_res.vers_hi = r_hi;
                    o_res.vers_lo = r_lo;
                end
            end
            default: ;
        endcase
    end

    // table cells: shift in at slot 0 on insert, move one slot per scan step on remove
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (do_shift) begin
                if (k == 0) begin
                    r_prog[k]  <= r_cmd.prog;
                    r_vers[k]  <= r_cmd.vers;
                    r_prot[k]  <= r_cmd.prot;
                    r_sport[k] <= r_cmd.port;
                    r_hash[k]  <= r_cmd.has_h;
                    r_hnd[k]   <= r_cmd.hid;
                end else begin
                    r_prog[k]  <= r_prog[k-1];
                    r_vers[k]  <= r_vers[k-1];
                    r_prot[k]  <= r_prot[k-1];
                    r_sport[k] <= r_sport[k-1];
                    r_hash[k]  <= r_hash[k-1];
                    r_hnd[k]   <= r_hnd[k-1];
                end
            end else if (do_move && (wi == IW'(k))) begin
                r_prog[k]  <= r_prog[ri];
                r_vers[k]  <= r_vers[ri];
                r_prot[k]  <= r_prot[ri];
                r_sport[k] <= r_sport[ri];
                r_hash[k]  <= r_hash[ri];
                r_hnd[k]   <= r_hnd[ri];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_wr      <= '0;
            r_hit     <= 1'b0;
            r_disp    <= 1'b0;
            r_port    <= '0;
            r_handler <= '0;
            r_status  <= ST_UNAVAILABLE;
            r_hi      <= '0;
            r_lo      <= LOW_START;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_take) begin
                        r_state   <= S_SCAN;
                        r_idx     <= '0;
                        r_wr      <= '0;
                        r_hit     <= 1'b0;
                        r_disp    <= 1'b0;
                        r_port    <= '0;
                        r_handler <= '0;
                        r_status  <= ST_UNAVAILABLE;
                        r_hi      <= '0;
                        r_lo      <= LOW_START;
                    end
                end
                S_SCAN: begin
                    if (at_end) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                        case (r_cmd.kind)
                            CMD_INSERT: if (tr_match) r_hit <= 1'b1;
                            CMD_REMOVE: begin
                                if (pv_match) r_hit <= 1'b1;
                                else          r_wr  <= r_wr + CW'(1);
                            end
                            CMD_PORT: begin
                                if (tr_match && !r_hit) begin
                                    r_hit  <= 1'b1;
                                    r_port <= r_sport[ri];
                                end
                            end
                            CMD_CALL: begin
                                if (!r_disp && (r_prog[ri] == r_cmd.prog)) begin
                                    r_status <= ST_MISMATCH;
                                    if ((r_vers[ri] == r_cmd.vers) && r_hash[ri]) begin
                                        r_disp    <= 1'b1;
                                        r_handler <= r_hnd[ri];
                                    end else begin
                                        if (r_vers[ri] > r_hi) r_hi <= r_vers[ri];
                                        if (r_vers[ri] < r_lo) r_lo <= r_vers[ri];
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DONE: begin
                    if (finish) begin
                        r_state <= S_IDLE;
                        if (do_shift) r_count <= r_count + CW'(1);
                        if (r_cmd.kind == CMD_REMOVE) r_count <= r_wr;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `RPMT_ASSERT_ALWAYS(a_count_bound, r_count <= DEPTH_C, "table count beyond depth")
    `RPMT_ASSERT_IMPL(a_scan_bound, r_state == S_SCAN, r_idx <= r_count, "scan past fill")
    `RPMT_ASSERT_IMPL(a_compact_order, r_state != S_IDLE, r_wr <= r_idx, "compaction overtook scan")
    `RPMT_ASSERT_IMPL(a_one_result, o_res_wr, $past(r_state) != S_IDLE, "result without scan")
endmodule

### rtl/rpmt_port_mapping_table_unit.sv
// Top level of the port mapping table.
// Depends on rpmt_pkg, rpmt_fifo, rpmt_front and rpmt_back.
//
// Usage:
//  Requests enter through a queue interface: a beat is taken when push is high
//  and full is low. Results leave through a queue interface: the oldest result
//  is on the o_ ports while empty is low and is taken when pop is high.
//  The trusted requester address is written on the cfg channel (always ready);
//  the user writes it only while the block is idle, not enforced by the block.
//  Each request gives exactly one result. The back stage takes one command at a
//  time from the request queue and scans the table one slot per cycle over the
//  entries in use (at most TABLE_DEPTH); rejected or unknown requests skip the
//  scan. It then writes the result into the result queue once there is room and
//  only then takes the next command. Two request beats and two result beats
//  can be buffered, so the front keeps accepting while a result waits; once
//  both queues fill, full stays high until pop frees room. Reset empties the
//  table and both queues and loads the loopback address as trusted requester.
module rpc_port_mapping_table_unit #(
    parameter int unsigned TABLE_DEPTH = rpmt_pkg::DEF_TABLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         i_operation,
    input  logic [31:0]        i_program_number,
    input  logic signed [31:0] i_version,
    input  logic [7:0]         i_protocol,
    input  logic [15:0]        i_port_number,
    input  logic [3:0]         i_handler_id,
    input  logic [31:0]        i_requester_addr,
    output logic               empty,
    input  logic               pop,
    output logic               o_success_flag,
    output logic [15:0]        o_port_out,
    output logic [1:0]         o_call_status,
    output logic [3:0]         o_handler_out,
    output logic signed [31:0] o_version_high,
    output logic signed [31:0] o_version_low,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data
);
    import rpmt_pkg::*;

    t_cmd    cmd;
    logic    cmd_empty, cmd_take;
    t_result res, res_q;
    logic    res_wr, res_full;
    logic [$bits(t_result)-1:0] res_bits;

    rpmt_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_operation      (i_operation),
        .i_program_number (i_program_number),
        .i_version        (i_version),
        .i_protocol       (i_protocol),
        .i_port_number    (i_port_number),
        .i_handler_id     (i_handler_id),
        .i_requester_addr (i_requester_addr),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_cmd            (cmd),
        .o_cmd_empty      (cmd_empty),
        .i_cmd_take       (cmd_take)
    );

    rpmt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_take  (cmd_take),
        .o_res       (res),
        .o_res_wr    (res_wr),
        .i_res_full  (res_full)
    );

    rpmt_fifo #(.WIDTH($bits(t_result))) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_wdata (res),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_rdata (res_bits),
        .o_empty (empty)
    );

    assign res_q          = t_result'(res_bits);
    assign o_success_flag = res_q.success;
    assign o_port_out     = res_q.port;
    assign o_call_status  = res_q.status;
    assign o_handler_out  = res_q.handler;
    assign o_version_high = res_q.vers_hi;
    assign o_version_low  = res_q.vers_lo;
endmodule
